// File: rtl/kmsd_pkg.sv
// Shared types, constants and key tables for the key matrix scanner.
package kmsd_pkg;

	localparam int RING_DEPTH_DEF  = 16;
	localparam int MAX_PRESSED_DEF = 8;
	localparam int TIME_BITS_DEF   = 48;

	localparam int NUM_SEL   = 8;
	localparam int NUM_ROW   = 7;
	localparam int NUM_CELLS = NUM_SEL * NUM_ROW;
	localparam int CELL_BITS = $clog2(NUM_CELLS);
	localparam int NOW_W     = 48;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;
	localparam int CHAR_W    = 7;
	localparam int CNT_W     = 32;

	localparam int SHIFT_COL = 1;
	localparam int SHIFT_ROW = 2;

	localparam logic MODE_POLL = 1'b0;
	localparam logic MODE_READ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SCAN_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_INTERVAL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_WINDOW = 2'd2;

	localparam logic [CFG_W-1:0] SCAN_INTERVAL_RST  = 20'd8000;
	localparam logic [CFG_W-1:0] RELEASE_WINDOW_RST = 20'd20000;

	localparam int QDEPTH = 2;

	localparam logic [CHAR_W-1:0] BASE_MAP [0:3][0:13] = '{
		'{7'h60, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		  7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08},
		'{7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79,
		  7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h5c},
		'{7'h00, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67,
		  7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b, 7'h27, 7'h0a},
		'{7'h00, 7'h00, 7'h00, 7'h7a, 7'h78, 7'h63, 7'h76,
		  7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h20}
	};

	localparam logic [CHAR_W-1:0] SHIFT_MAP [0:3][0:13] = '{
		'{7'h7e, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e,
		  7'h26, 7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08},
		'{7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59,
		  7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h7c},
		'{7'h00, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47,
		  7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a, 7'h22, 7'h0a},
		'{7'h00, 7'h00, 7'h00, 7'h5a, 7'h58, 7'h43, 7'h56,
		  7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h20}
	};

	// classified item passed from front to back
	typedef struct packed {
		logic                 mode;
		logic [NUM_CELLS-1:0] kept;
		logic                 cand_found;
		logic [CELL_BITS-1:0] cand_cell;
		logic [CHAR_W-1:0]    cand_char;
		logic [NOW_W-1:0]     now;
	} queue_entry_t;

endpackage

// File: rtl/kmsd_front.sv
// Front end: accepts items, classifies the matrix snapshot and queues the result.
module kmsd_front #(
	parameter int MAX_PRESSED = kmsd_pkg::MAX_PRESSED_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic [kmsd_pkg::NUM_CELLS-1:0] row_levels,
	input  logic [kmsd_pkg::NOW_W-1:0]   now_us,
	output logic                         q_valid,
	output kmsd_pkg::queue_entry_t       q_head,
	input  logic                         q_pop
);

	localparam int QPW = $clog2(kmsd_pkg::QDEPTH);

	logic [kmsd_pkg::NUM_CELLS-1:0] pressed;
	logic [kmsd_pkg::NUM_CELLS-1:0] kept;
	logic                           shift;
	kmsd_pkg::queue_entry_t         entry;
	kmsd_pkg::queue_entry_t         queue_q [kmsd_pkg::QDEPTH];
	logic [QPW-1:0]                 wr_ptr_q, rd_ptr_q;
	logic [QPW:0]                   count_q;
	logic                           push;

	assign pressed = ~row_levels;

	// a cell is kept when fewer than MAX_PRESSED pressed cells come before it
	always_comb begin
		for (int i = 0; i < kmsd_pkg::NUM_CELLS; i++) begin
			kept[i] = pressed[i] &&
				($countones(pressed & ((kmsd_pkg::NUM_CELLS'(1) << i) -
				kmsd_pkg::NUM_CELLS'(1))) < MAX_PRESSED);
		end
		// the shift cell sits on select 1, row 0; that select is scanned only
		// while select 0 left room
		shift = pressed[kmsd_pkg::NUM_ROW] &&
			($countones(pressed[kmsd_pkg::NUM_ROW-1:0]) < MAX_PRESSED);
	end

	// pick the first kept cell that has a character; scan high to low so the
	// lowest cell wins
	always_comb begin
		int x, y;
		logic [kmsd_pkg::CHAR_W-1:0] c;
		entry            = '0;
		entry.mode       = mode;
		entry.kept       = kept;
		entry.now        = now_us;
		for (int s = kmsd_pkg::NUM_SEL - 1; s >= 0; s--) begin
			for (int r = kmsd_pkg::NUM_ROW - 1; r >= 0; r--) begin
				x = (s > 3) ? 2 * r : 2 * r + 1;
				y = 3 - (s & 3);
				c = shift ? kmsd_pkg::SHIFT_MAP[y][x] : kmsd_pkg::BASE_MAP[y][x];
				if (kept[s * kmsd_pkg::NUM_ROW + r] && c != '0) begin
					entry.cand_found = 1'b1;
					entry.cand_cell  = kmsd_pkg::CELL_BITS'(s * kmsd_pkg::NUM_ROW + r);
					entry.cand_char  = c;
				end
			end
		end
	end

	assign in_stall = (count_q == (QPW+1)'(kmsd_pkg::QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_head   = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !q_pop) count_q <= count_q + 1'b1;
			else if (!push && q_pop) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) queue_q[wr_ptr_q] <= entry;
	end

endmodule

// File: rtl/kmsd_back.sv
// Back end: debounce latch, character ring, configuration and result register.
module kmsd_back #(
	parameter int RING_DEPTH = kmsd_pkg::RING_DEPTH_DEF,
	parameter int TIME_BITS  = kmsd_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [kmsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kmsd_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             q_valid,
	input  kmsd_pkg::queue_entry_t           q_head,
	output logic                             q_pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             key_found,
	output logic [kmsd_pkg::CHAR_W-1:0]      key_code,
	output logic                             queued,
	output logic                             dropped,
	output logic [kmsd_pkg::CHAR_W-1:0]      read_char,
	output logic [kmsd_pkg::CNT_W-1:0]       event_count
);

	localparam int PW = $clog2(RING_DEPTH);

	logic                           scan_enable_q;
	logic [kmsd_pkg::CFG_W-1:0]     scan_interval_q, release_window_q;
	logic                           latch_valid_q;
	logic [kmsd_pkg::CELL_BITS-1:0] latch_cell_q;
	logic [TIME_BITS-1:0]           last_down_q, last_scan_q;
	logic [PW-1:0]                  wr_ptr_q, rd_ptr_q;
	logic [kmsd_pkg::CNT_W-1:0]     total_q;
	logic [kmsd_pkg::CHAR_W-1:0]    ring_q [RING_DEPTH];
	logic                           out_valid_q;

	logic [TIME_BITS-1:0] now_t, scan_diff, down_diff;
	logic                 poll_ok, held, new_key, ring_full, ring_empty;
	logic                 do_push, do_pop;
	logic [PW-1:0]        wr_next, rd_next;

	assign q_pop     = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	assign now_t     = TIME_BITS'(q_head.now);
	assign scan_diff = now_t - last_scan_q;
	assign down_diff = now_t - last_down_q;
	assign poll_ok   = (q_head.mode == kmsd_pkg::MODE_POLL) && scan_enable_q &&
		(scan_diff >= TIME_BITS'(scan_interval_q));
	assign held      = latch_valid_q && q_head.kept[latch_cell_q];
	assign new_key   = poll_ok && q_head.cand_found &&
		!(latch_valid_q && (q_head.cand_cell == latch_cell_q || held));

	assign wr_next    = (wr_ptr_q == PW'(RING_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next    = (rd_ptr_q == PW'(RING_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
	assign ring_full  = (wr_next == rd_ptr_q);
	assign ring_empty = (wr_ptr_q == rd_ptr_q);
	assign do_push    = q_pop && new_key && !ring_full;
	assign do_pop     = q_pop && (q_head.mode == kmsd_pkg::MODE_READ) && !ring_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_enable_q    <= 1'b0;
			scan_interval_q  <= kmsd_pkg::SCAN_INTERVAL_RST;
			release_window_q <= kmsd_pkg::RELEASE_WINDOW_RST;
			latch_valid_q    <= 1'b0;
			latch_cell_q     <= '0;
			last_down_q      <= '0;
			last_scan_q      <= '0;
			wr_ptr_q         <= '0;
			rd_ptr_q         <= '0;
			total_q          <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					kmsd_pkg::REG_SCAN_ENABLE:    scan_enable_q    <= cfg_data[0];
					kmsd_pkg::REG_SCAN_INTERVAL:  scan_interval_q  <= cfg_data;
					kmsd_pkg::REG_RELEASE_WINDOW: release_window_q <= cfg_data;
					default: ;
				endcase
			end
			if (q_pop) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (q_pop && poll_ok) begin
				last_scan_q <= now_t;
				if (held || new_key) last_down_q <= now_t;
				// drop the latch once released for longer than the window
				if (!q_head.cand_found && !held &&
				    down_diff > TIME_BITS'(release_window_q))
					latch_valid_q <= 1'b0;
				if (new_key) begin
					latch_valid_q <= 1'b1;
					latch_cell_q  <= q_head.cand_cell;
				end
			end
			if (do_push) begin
				wr_ptr_q <= wr_next;
				total_q  <= total_q + 1'b1;
			end
			if (do_pop) rd_ptr_q <= rd_next;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ring_q[wr_ptr_q] <= q_head.cand_char;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			key_found   <= new_key;
			key_code    <= new_key ? q_head.cand_char : '0;
			queued      <= new_key && !ring_full;
			dropped     <= new_key && ring_full;
			read_char   <= do_pop ? ring_q[rd_ptr_q] : '0;
			event_count <= do_push ? total_q + 1'b1 : total_q;
		end
	end

endmodule

// File: rtl/key_matrix_scan_debounce_fifo_top.sv
// Key matrix scanner top level: front classifier, two-entry queue, back end.
// An input transaction passes the queue register and then the back end's
// result registers. Throughput: one transaction per cycle while out_stall is
// low; the back end's latch and ring update and the two-entry queue set this figure.
// Reset: arst_n clears queue, latch, ring pointers, counters and config to
// their defaults at once; ring contents stay undefined until written.
module key_matrix_scan_debounce_fifo_top #(
	parameter int RING_DEPTH  = kmsd_pkg::RING_DEPTH_DEF,
	parameter int MAX_PRESSED = kmsd_pkg::MAX_PRESSED_DEF,
	parameter int TIME_BITS   = kmsd_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [kmsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kmsd_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             mode,
	input  logic [kmsd_pkg::NUM_CELLS-1:0]   row_levels,
	input  logic [kmsd_pkg::NOW_W-1:0]       now_us,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             key_found,
	output logic [kmsd_pkg::CHAR_W-1:0]      key_code,
	output logic                             queued,
	output logic                             dropped,
	output logic [kmsd_pkg::CHAR_W-1:0]      read_char,
	output logic [kmsd_pkg::CNT_W-1:0]       event_count
);

	logic                   q_valid, q_pop;
	kmsd_pkg::queue_entry_t q_head;

	kmsd_front #(.MAX_PRESSED(MAX_PRESSED)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .mode, .row_levels, .now_us,
		.q_valid, .q_head, .q_pop
	);

	kmsd_back #(.RING_DEPTH(RING_DEPTH), .TIME_BITS(TIME_BITS)) u_back (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.q_valid, .q_head, .q_pop,
		.out_valid, .out_stall, .key_found, .key_code, .queued, .dropped,
		.read_char, .event_count
	);

	a_found_split: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_found |-> (queued ^ dropped))
		else $error("keystroke neither queued nor dropped exactly once");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !key_found |-> !queued && !dropped && key_code == '0)
		else $error("flags set without a keystroke");

	a_read_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_char != '0 |-> !key_found)
		else $error("read result carries a keystroke");

endmodule

// File: tb/key_matrix_scan_debounce_fifo_checker.sv
// Keystroke predictor and result scoreboard for the key matrix scanner.
`timescale 1ns / 100ps

module key_matrix_scan_debounce_fifo_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [kmsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kmsd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           mode,
	input  logic [kmsd_pkg::NUM_CELLS-1:0] row_levels,
	input  logic [kmsd_pkg::NOW_W-1:0]     now_us,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           key_found,
	input  logic [kmsd_pkg::CHAR_W-1:0]    key_code,
	input  logic                           queued,
	input  logic                           dropped,
	input  logic [kmsd_pkg::CHAR_W-1:0]    read_char,
	input  logic [kmsd_pkg::CNT_W-1:0]     event_count,
	output int                             fail_count,
	output int                             pending,
	output int                             keys_seen,
	output int                             drops_seen
);

	typedef struct {
		logic                        found;
		logic [kmsd_pkg::CHAR_W-1:0] code;
		logic                        q;
		logic                        drop;
		logic [kmsd_pkg::CHAR_W-1:0] rchar;
		logic [kmsd_pkg::CNT_W-1:0]  count;
	} key_result_t;

	key_result_t expected_results[$];

	logic                        enable_r;
	logic [kmsd_pkg::CFG_W-1:0]  interval_r;
	logic [kmsd_pkg::CFG_W-1:0]  window_r;
	logic                        latched;
	logic [3:0]                  lat_x;
	logic [1:0]                  lat_y;
	logic [kmsd_pkg::NOW_W-1:0]  down_time;
	logic [kmsd_pkg::NOW_W-1:0]  scan_time;
	logic [kmsd_pkg::CHAR_W-1:0] ring [0:15];
	logic [3:0]                  wr_ptr;
	logic [3:0]                  rd_ptr;
	logic [kmsd_pkg::CNT_W-1:0]  total;

	// One matrix scan; returns the new character or zero.
	function automatic logic [kmsd_pkg::CHAR_W-1:0] scan_keys(
			logic [kmsd_pkg::NUM_CELLS-1:0] lv, logic [kmsd_pkg::NOW_W-1:0] t);
		int xs[kmsd_pkg::MAX_PRESSED_DEF];
		int ys[kmsd_pkg::MAX_PRESSED_DEF];
		int n;
		int x;
		int y;
		bit shift;
		bit held;
		logic [kmsd_pkg::CHAR_W-1:0] ch;
		int cx;
		int cy;
		n = 0;
		shift = 0;
		held = 0;
		ch = '0;
		cx = 0;
		cy = 0;
		for (int s = 0; s < kmsd_pkg::NUM_SEL && n < kmsd_pkg::MAX_PRESSED_DEF; s++) begin
			for (int r = 0; r < kmsd_pkg::NUM_ROW; r++) begin
				if (!lv[s*kmsd_pkg::NUM_ROW + r]) begin
					x = (s > 3) ? 2*r : 2*r + 1;
					y = 3 - (s % 4);
					if (x == kmsd_pkg::SHIFT_COL && y == kmsd_pkg::SHIFT_ROW)
						shift = 1;
					if (n < kmsd_pkg::MAX_PRESSED_DEF) begin
						xs[n] = x;
						ys[n] = y;
						n++;
					end
				end
			end
		end
		for (int k = 0; k < n; k++)
			if (latched && xs[k] == lat_x && ys[k] == lat_y)
				held = 1;
		if (held)
			down_time = t;
		for (int k = 0; k < n; k++) begin
			ch = shift ? kmsd_pkg::SHIFT_MAP[ys[k]][xs[k]] :
				kmsd_pkg::BASE_MAP[ys[k]][xs[k]];
			if (ch != 0) begin
				cx = xs[k];
				cy = ys[k];
				break;
			end
		end
		if (ch == 0) begin
			if (!held && (t - down_time) > {28'd0, window_r})
				latched = 0;
			return '0;
		end
		if (latched && cx == lat_x && cy == lat_y)
			return '0;
		if (latched && held)
			return '0;
		latched = 1;
		lat_x = cx;
		lat_y = cy;
		down_time = t;
		return ch;
	endfunction

	task automatic predict(logic m, logic [kmsd_pkg::NUM_CELLS-1:0] lv,
			logic [kmsd_pkg::NOW_W-1:0] t);
		key_result_t e;
		logic [kmsd_pkg::CHAR_W-1:0] c;
		e = '{default: '0};
		if (m == kmsd_pkg::MODE_READ) begin
			if (rd_ptr != wr_ptr) begin
				e.rchar = ring[rd_ptr];
				rd_ptr = rd_ptr + 1;
			end
		end else if (enable_r && (t - scan_time) >= {28'd0, interval_r}) begin
			scan_time = t;
			c = scan_keys(lv, t);
			if (c != 0) begin
				e.found = 1;
				e.code = c;
				keys_seen++;
				if (4'(wr_ptr + 1) == rd_ptr) begin
					e.drop = 1;
					drops_seen++;
				end else begin
					ring[wr_ptr] = c;
					wr_ptr = wr_ptr + 1;
					total = total + 1;
					e.q = 1;
				end
			end
		end
		e.count = total;
		expected_results.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		key_result_t e;
		if (!arst_n) begin
			enable_r = 0;
			interval_r = kmsd_pkg::SCAN_INTERVAL_RST;
			window_r = kmsd_pkg::RELEASE_WINDOW_RST;
			latched = 0;
			lat_x = 0;
			lat_y = 0;
			down_time = 0;
			scan_time = 0;
			wr_ptr = 0;
			rd_ptr = 0;
			total = 0;
			fail_count = 0;
			keys_seen = 0;
			drops_seen = 0;
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					kmsd_pkg::REG_SCAN_ENABLE: enable_r = cfg_data[0];
					kmsd_pkg::REG_SCAN_INTERVAL: interval_r = cfg_data;
					kmsd_pkg::REG_RELEASE_WINDOW: window_r = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict(mode, row_levels, now_us);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					if (key_found !== e.found) begin
						$error("key_found exp %0h got %0h", e.found, key_found);
						fail_count++;
					end
					if (key_code !== e.code) begin
						$error("key_code exp %0h got %0h", e.code, key_code);
						fail_count++;
					end
					if (queued !== e.q) begin
						$error("queued exp %0h got %0h", e.q, queued);
						fail_count++;
					end
					if (dropped !== e.drop) begin
						$error("dropped exp %0h got %0h", e.drop, dropped);
						fail_count++;
					end
					if (read_char !== e.rchar) begin
						$error("read_char exp %0h got %0h", e.rchar, read_char);
						fail_count++;
					end
					if (event_count !== e.count) begin
						$error("event_count exp %0h got %0h", e.count, event_count);
						fail_count++;
					end
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

// File: tb/key_matrix_scan_debounce_fifo_top_tb.sv
// Stimulus, flow control and verdict for the key matrix scanner testbench.
`timescale 1ns / 100ps

module key_matrix_scan_debounce_fifo_top_tb;

	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [kmsd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [kmsd_pkg::CFG_W-1:0]     cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	logic                           mode;
	logic [kmsd_pkg::NUM_CELLS-1:0] row_levels;
	logic [kmsd_pkg::NOW_W-1:0]     now_us;
	logic                           out_valid;
	logic                           out_stall;
	logic                           key_found;
	logic [kmsd_pkg::CHAR_W-1:0]    key_code;
	logic                           queued;
	logic                           dropped;
	logic [kmsd_pkg::CHAR_W-1:0]    read_char;
	logic [kmsd_pkg::CNT_W-1:0]     event_count;

	int fail_count;
	int pending;
	int keys_seen;
	int drops_seen;

	int hold_ask;
	int idle_cycles;
	int items_sent;
	int burst_left;
	int read_pct;
	logic [kmsd_pkg::NOW_W-1:0] clock_us;
	logic [kmsd_pkg::CFG_W-1:0] intv;
	logic [kmsd_pkg::CFG_W-1:0] win;

	key_matrix_scan_debounce_fifo_top DUT (.*);

	key_matrix_scan_debounce_fifo_checker scoreboard (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Receiver: draws a random stall pattern (none, light, heavy); a hold request wins.
	initial begin
		int hold_done;
		int hold_left;
		int style;
		int cyc;
		out_stall = 0;
		hold_done = 0;
		hold_left = 0;
		style = 0;
		cyc = 0;
		forever begin
			@(negedge clk);
			if (hold_ask != hold_done) begin
				hold_done = hold_ask;
				hold_left = HOLD_CYCLES;
			end
			if (cyc % 64 == 0)
				style = $urandom_range(0, 2);
			cyc++;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1;
			end else
				case (style)
					0: out_stall <= 0;
					1: out_stall <= ($urandom_range(0, 99) < 30);
					default: out_stall <= ($urandom_range(0, 99) < 70);
				endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(logic [kmsd_pkg::CFG_IDX_W-1:0] idx,
			logic [kmsd_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == kmsd_pkg::REG_SCAN_INTERVAL)
			intv = val;
		if (idx == kmsd_pkg::REG_RELEASE_WINDOW)
			win = val;
	endtask

	task automatic send(logic m, logic [kmsd_pkg::NUM_CELLS-1:0] lv,
			logic [kmsd_pkg::NOW_W-1:0] t);
		if (burst_left == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1;
		mode <= m;
		row_levels <= lv;
		now_us <= t;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		burst_left = 0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Poll at a time advanced by dt.
	task automatic poll_at(logic [kmsd_pkg::NOW_W-1:0] dt,
			logic [kmsd_pkg::NUM_CELLS-1:0] lv);
		clock_us = clock_us + dt;
		send(kmsd_pkg::MODE_POLL, lv, clock_us);
	endtask

	function automatic logic [kmsd_pkg::NUM_CELLS-1:0] press(int key_pos, bit shift);
		logic [kmsd_pkg::NUM_CELLS-1:0] lv;
		lv = '1;
		lv[key_pos] = 0;
		if (shift)
			lv[kmsd_pkg::SHIFT_COL*0 + 7] = 0;
		return lv;
	endfunction

	task automatic maybe_read();
		if ($urandom_range(0, 99) < read_pct)
			send(kmsd_pkg::MODE_READ, kmsd_pkg::NUM_CELLS'({$urandom, $urandom}),
				kmsd_pkg::NOW_W'({$urandom, $urandom}));
	endtask

	// Press, hold, maybe overlap a second key, then release past the window.
	task automatic keystroke_seq();
		int key_pos;
		int other;
		bit sh;
		logic [kmsd_pkg::NUM_CELLS-1:0] lv;
		key_pos = $urandom_range(0, kmsd_pkg::NUM_CELLS - 1);
		sh = ($urandom_range(0, 99) < 30);
		lv = press(key_pos, sh);
		repeat ($urandom_range(1, 3)) begin
			poll_at(kmsd_pkg::NOW_W'(intv + $urandom_range(0, 3)), lv);
			maybe_read();
		end
		if ($urandom_range(0, 99) < 25) begin
			other = $urandom_range(0, kmsd_pkg::NUM_CELLS - 1);
			lv[other] = 0;
			poll_at(kmsd_pkg::NOW_W'(intv + $urandom_range(0, 3)), lv);
		end
		repeat ($urandom_range(1, 2)) begin
			poll_at(kmsd_pkg::NOW_W'(intv + win + 1 + $urandom_range(0, 3)), '1);
			maybe_read();
		end
	endtask

	task automatic noise_item();
		logic [kmsd_pkg::NOW_W-1:0] t;
		case ($urandom_range(0, 3))
			0: send(kmsd_pkg::MODE_READ, kmsd_pkg::NUM_CELLS'({$urandom, $urandom}),
				kmsd_pkg::NOW_W'({$urandom, $urandom}));
			1: begin
				// clock jumps anywhere, possibly backwards
				t = kmsd_pkg::NOW_W'({$urandom, $urandom});
				clock_us = t;
				send(kmsd_pkg::MODE_POLL, kmsd_pkg::NUM_CELLS'({$urandom, $urandom}), t);
			end
			2: poll_at(kmsd_pkg::NOW_W'($urandom_range(0, intv)),
				kmsd_pkg::NUM_CELLS'({$urandom, $urandom}));
			default: poll_at(kmsd_pkg::NOW_W'(intv + $urandom_range(0, 5)),
				kmsd_pkg::NUM_CELLS'({$urandom, $urandom}));
		endcase
	endtask

	task automatic run_phase(logic en, logic [kmsd_pkg::CFG_W-1:0] iv,
			logic [kmsd_pkg::CFG_W-1:0] wv, int n, int rp, bit hold);
		int stop_at;
		write_reg(kmsd_pkg::REG_SCAN_ENABLE, {19'd0, en});
		write_reg(kmsd_pkg::REG_SCAN_INTERVAL, iv);
		write_reg(kmsd_pkg::REG_RELEASE_WINDOW, wv);
		read_pct = rp;
		if (hold)
			hold_ask++;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 75)
				keystroke_seq();
			else
				noise_item();
		end
		drain();
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		mode = 0;
		row_levels = '1;
		now_us = '0;
		hold_ask = 0;
		items_sent = 0;
		burst_left = 0;
		read_pct = 20;
		clock_us = '0;
		intv = kmsd_pkg::SCAN_INTERVAL_RST;
		win = kmsd_pkg::RELEASE_WINDOW_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: a disabled poll, an empty read, then edge cases at reset timing.
		send(kmsd_pkg::MODE_POLL, press(20, 0), 48'd9000);
		send(kmsd_pkg::MODE_READ, '0, '0);
		drain();
		write_reg(kmsd_pkg::REG_SCAN_ENABLE, 20'd1);
		send(kmsd_pkg::MODE_POLL, press(20, 0), 48'd7999);
		send(kmsd_pkg::MODE_POLL, press(20, 0), 48'd8000);
		send(kmsd_pkg::MODE_POLL, press(20, 0), 48'd16000);
		send(kmsd_pkg::MODE_POLL, '1, 48'd24000);
		send(kmsd_pkg::MODE_POLL, '1, 48'd60000);
		send(kmsd_pkg::MODE_POLL, press(30, 1), 48'd70000);
		send(kmsd_pkg::MODE_POLL, press(7, 0), 48'd80000);
		send(kmsd_pkg::MODE_POLL, '0, 48'd200000);
		send(kmsd_pkg::MODE_POLL, '1, 48'd300000);
		send(kmsd_pkg::MODE_POLL, '0, 48'hFFFF_FFFF_FFFF);
		send(kmsd_pkg::MODE_POLL, '1, 48'd5);
		send(kmsd_pkg::MODE_POLL, {8'h00, 48'hFFFF_FFFF_FFFF}, 48'd100000);
		send(kmsd_pkg::MODE_READ, '1, '1);
		send(kmsd_pkg::MODE_READ, '0, '0);
		send(kmsd_pkg::MODE_READ, '1, '0);
		send(kmsd_pkg::MODE_READ, '0, '1);
		drain();
		clock_us = 48'd400000;

		// Drain with the sender paused, then walk through settings.
		run_phase(1, 20'd0, 20'd0, 330, 20, 0);
		run_phase(1, 20'hFFFFF, 20'hFFFFF, 330, 25, 0);
		run_phase(1, 20'd50, 20'd200, 330, 3, 1);
		run_phase(1, 20'd3, 20'd10, 330, 45, 0);
		run_phase(0, 20'd0, 20'd0, 150, 30, 0);
		run_phase(1, 20'd8000, 20'd20000, 400, 15, 1);

		$display("sent %0d transactions: %0d keystrokes predicted, %0d dropped on full ring",
			items_sent, keys_seen, drops_seen);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
